[sv/b64d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and helper functions of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int RES_DEPTH      = 3;   // results one item can cause

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
	localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '=', never part of the alphabet

	localparam logic [5:0] MASK_HI2 = 6'h30;
	localparam logic [5:0] MASK_HI4 = 6'h3C;
	localparam logic [5:0] MASK_LO2 = 6'h03;
	localparam logic [5:0] MASK_LO4 = 6'h0F;

	localparam logic [15:0] REPORT_MAX = 16'hFFFF;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	typedef struct packed {
		logic [15:0] message_bytes;
		logic        message_end;
		logic        run_last;
		logic        byte_valid;
		logic [7:0]  data_byte;
	} res_t;

	// Map an ASCII code to its six-bit value; valid is low outside the alphabet.
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.valid = 1'b1;
		s.value = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == CHAR_PLUS) begin
			s.value = 6'd62;
		end else if (c == CHAR_SLASH) begin
			s.value = 6'd63;
		end else begin
			s.valid = 1'b0;
		end
		return s;
	endfunction

	// Three bytes of a group, first byte in the low bits.
	function automatic logic [23:0] group_bytes(input logic [5:0] s0, input logic [5:0] s1,
	                                            input logic [5:0] s2, input logic [5:0] s3);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		b0 = {s0, 2'(((s1 & MASK_HI2) >> 4))};
		b1 = {4'(s1 & MASK_LO4), 4'(((s2 & MASK_HI4) >> 2))};
		b2 = {2'(s2 & MASK_LO2), s3};
		return {b2, b1, b0};
	endfunction

endpackage

[sv/base64_stream_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Standard-alphabet base64 decoder, one character per item in, one decoded
// byte or end report per item out.
// ----------------------------------------------------------------------------
//
// channel  dir  tdata (low bit up)                  tuser                     tlast
// s_axis   in   character[7:0]                      has_character             end_of_message
// m_axis   out  data_byte[7:0], message_bytes[15:0] byte_valid, message_end   run_last
//
// Cycles: one character is accepted per clock while the result register is empty or its last
// waiting result leaves. The decode, the flush and the byte count all settle in one pass
// straight into a three-entry result register, which drains through m_axis one result per
// clock while m_axis_tready is high; a character that completes a group therefore keeps
// s_axis_tready low until the last of its three bytes leaves over the single output port.
// Reset: arst_n clears the pending group, the stop flag, the byte count and
// the result count at once; the result payload has no reset.
// Stalls: the next item is taken while the last waiting result goes out.
//
module base64_stream_decoder #(
	parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] character
	input  logic        s_axis_tuser,   // [0] has_character
	input  logic        s_axis_tlast,   // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] message_bytes
	output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] message_end
	output logic        m_axis_tlast    // run_last
);
	import b64d_pkg::*;

	// decoder state
	logic [5:0]            sext_q [RES_DEPTH];
	logic [1:0]            pcount_q;
	logic                  stopped_q;
	logic [COUNT_BITS-1:0] total_q;

	// result register, entry 0 faces the output
	res_t       res_q [RES_DEPTH];
	logic [1:0] rcount_q;

	logic in_fire;
	logic out_fire;

	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (rcount_q != 2'd0);
	// accept when empty, or when the last waiting result leaves this cycle
	assign s_axis_tready = (rcount_q == 2'd0) || ((rcount_q == 2'd1) && m_axis_tready);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign m_axis_tdata  = {res_q[0].message_bytes, res_q[0].data_byte};
	assign m_axis_tuser  = {res_q[0].message_end, res_q[0].byte_valid};
	assign m_axis_tlast  = res_q[0].run_last;

	// ---------------------------------------------------------------------
	// single-pass decode of the incoming item
	// ---------------------------------------------------------------------
	sextet_t               dec;
	logic                  use_char;
	logic [5:0]            sext_nx [RES_DEPTH];
	logic [1:0]            pcount_nx;
	logic                  stopped_nx;
	logic [5:0]            g0, g1, g2, g3;
	logic [1:0]            nbytes;
	logic [1:0]            nres;
	logic [23:0]           bytes;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] total_nx;
	logic [31:0]           total_ext;
	logic [15:0]           report;
	res_t                  res_nx [RES_DEPTH];

	always_comb begin
		dec        = sextet_of(s_axis_tdata);
		use_char   = s_axis_tuser && !stopped_q;
		sext_nx    = sext_q;
		pcount_nx  = pcount_q;
		stopped_nx = stopped_q;
		g0         = sext_q[0];
		g1         = sext_q[1];
		g2         = sext_q[2];
		g3         = dec.value;
		nbytes     = 2'd0;

		if (use_char && dec.valid && pcount_q == 2'd3) begin
			// fourth character completes a group
			nbytes    = 2'd3;
			pcount_nx = 2'd0;
		end else if (use_char && dec.valid) begin
			sext_nx[pcount_q] = dec.value;
			pcount_nx         = pcount_q + 2'd1;
		end else if (use_char) begin
			// pad or stray character: flush the partial group and stop
			nbytes     = (pcount_q >= 2'd2) ? pcount_q - 2'd1 : 2'd0;
			pcount_nx  = 2'd0;
			stopped_nx = 1'b1;
		end

		// end flush of a partial group of two or three characters
		if (s_axis_tlast && !stopped_nx && pcount_nx >= 2'd2) begin
			g0     = sext_nx[0];
			g1     = sext_nx[1];
			g2     = sext_nx[2];
			nbytes = pcount_nx - 2'd1;
		end

		bytes     = group_bytes(g0, g1, g2, g3);
		sum       = {1'b0, total_q} + (COUNT_BITS+1)'(nbytes);
		total_nx  = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
		total_ext = 32'(total_nx);
		report    = (total_ext > 32'(REPORT_MAX)) ? REPORT_MAX : total_ext[15:0];
		nres      = ((s_axis_tlast && nbytes == 2'd0) ? 2'd1 : nbytes);

		for (int i = 0; i < RES_DEPTH; i++) begin
			res_nx[i].byte_valid    = (2'(i) < nbytes);
			res_nx[i].data_byte     = res_nx[i].byte_valid ? bytes[8*i +: 8] : 8'd0;
			res_nx[i].run_last      = (2'(i) == nres - 2'd1);
			res_nx[i].message_end   = s_axis_tlast && res_nx[i].run_last;
			res_nx[i].message_bytes = res_nx[i].message_end ? report : 16'd0;
		end
	end

	// ---------------------------------------------------------------------
	// state update; an end item returns everything to the reset values
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RES_DEPTH; i++) begin
				sext_q[i] <= 6'd0;
			end
			pcount_q  <= 2'd0;
			stopped_q <= 1'b0;
			total_q   <= '0;
		end else if (in_fire) begin
			if (s_axis_tlast) begin
				for (int i = 0; i < RES_DEPTH; i++) begin
					sext_q[i] <= 6'd0;
				end
				pcount_q  <= 2'd0;
				stopped_q <= 1'b0;
				total_q   <= '0;
			end else begin
				sext_q    <= sext_nx;
				pcount_q  <= pcount_nx;
				stopped_q <= stopped_nx;
				total_q   <= total_nx;
			end
		end
	end

	// result count: load on a fresh item, otherwise drop one per output item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcount_q <= 2'd0;
		end else if (in_fire) begin
			rcount_q <= nres;
		end else if (out_fire) begin
			rcount_q <= rcount_q - 2'd1;
		end
	end

	// result payload: load, or advance toward entry 0
	always_ff @(posedge clk) begin
		if (in_fire && nres != 2'd0) begin
			res_q <= res_nx;
		end else if (out_fire) begin
			for (int i = 0; i < RES_DEPTH - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

endmodule

[sv/b64d_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// the end report closes the run of its item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("message end without tlast");

	// a result without a byte is a bare end report
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[1] && m_axis_tdata[7:0] == 8'd0)
		else $error("empty result that is not an end report");

	// the byte count shows only on the end report
	a_count_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[23:8] == 16'd0)
		else $error("byte count outside the end report");

	// an item is taken only while the result register can hold its results
	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && m_axis_tvalid |-> m_axis_tready)
		else $error("item accepted over a waiting result");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

[tb/base64_stream_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Self-checking bench for the base64 stream decoder. Directed strings cover
// full groups, padding, stray characters, bare end markers and alphabet
// extremes. Random messages follow under several idle and stall mixes,
// then a long back-pressure hold. A tracker class predicts every result item.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 200;
	localparam int MAX_REPORTS    = 40;

	// Predict and check the decoder output, one item at a time
	class decode_tracker;
		bit [5:0]         pend [3];
		bit [1:0]         pend_cnt;
		bit               stopped;
		bit [15:0]        byte_total;
		b64d_pkg::res_t   bytes_due [$];
		int unsigned      errors;

		// Six-bit value of an alphabet character; ok low outside the alphabet
		static function bit [5:0] char_sextet(input bit [7:0] c, output bit ok);
			ok = 1'b1;
			if (c >= "A" && c <= "Z") return 6'(c - "A");
			if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
			if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
			if (c == "+") return 6'd62;
			if (c == "/") return 6'd63;
			ok = 1'b0;
			return 6'd0;
		endfunction

		function void push_byte(ref b64d_pkg::res_t run [$], input bit [7:0] b);
			b64d_pkg::res_t r;
			r = '0;
			r.data_byte = b;
			r.byte_valid = 1'b1;
			run.push_back(r);
			if (byte_total != 16'hFFFF) byte_total++;
		endfunction

		// Emit k-1 bytes for a partial group of k sextets
		function void flush(ref b64d_pkg::res_t run [$]);
			if (pend_cnt >= 2) push_byte(run, {pend[0], pend[1][5:4]});
			if (pend_cnt == 3) push_byte(run, {pend[1][3:0], pend[2][5:2]});
			pend_cnt = 0;
		endfunction

		// Note an accepted input item and queue the results it causes
		function void take_char(input bit [7:0] ch, input bit has, input bit eom);
			b64d_pkg::res_t run [$];
			b64d_pkg::res_t r;
			bit [5:0]       v;
			bit             ok;
			if (has && !stopped) begin
				v = char_sextet(ch, ok);
				if (!ok) begin
					flush(run);
					stopped = 1'b1;
				end else if (pend_cnt == 3) begin
					push_byte(run, {pend[0], pend[1][5:4]});
					push_byte(run, {pend[1][3:0], pend[2][5:2]});
					push_byte(run, {pend[2][1:0], v});
					pend_cnt = 0;
				end else begin
					pend[pend_cnt] = v;
					pend_cnt++;
				end
			end
			if (eom) begin
				if (!stopped) flush(run);
				if (run.size() == 0) begin
					r = '0;
					run.push_back(r);
				end
				run[run.size() - 1].message_end = 1'b1;
				run[run.size() - 1].message_bytes = byte_total;
				pend = '{default: 6'd0};
				pend_cnt = 0;
				stopped = 1'b0;
				byte_total = 0;
			end
			if (run.size() != 0) run[run.size() - 1].run_last = 1'b1;
			foreach (run[i]) bytes_due.push_back(run[i]);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		// Check one accepted result against the oldest prediction
		function void check_result(input b64d_pkg::res_t got);
			b64d_pkg::res_t want;
			if (bytes_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result expected none, got %h", $time, got);
				return;
			end
			want = bytes_due.pop_front();
			compare("data_byte", want.data_byte, got.data_byte);
			compare("byte_valid", want.byte_valid, got.byte_valid);
			compare("run_last", want.run_last, got.run_last);
			compare("message_end", want.message_end, got.message_end);
			compare("message_bytes", want.message_bytes, got.message_bytes);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] character
	logic        s_axis_tuser = 1'b0;   // [0] has_character
	logic        s_axis_tlast = 1'b0;   // end_of_message
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;          // [7:0] data_byte, [23:8] message_bytes
	logic [1:0]  m_axis_tuser;          // [0] byte_valid, [1] message_end
	logic        m_axis_tlast;          // run_last

	decode_tracker tracker = new;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	int unsigned   items_sent = 0;
	int unsigned   hold_left = 0;
	int unsigned   quiet_cycles = 0;
	bit            hold_req = 1'b0;

	base64_stream_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: stall at random, or hold off for a long stretch on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check results before noting the item accepted at the same edge
	always @(posedge clk) begin
		b64d_pkg::res_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.data_byte = m_axis_tdata[7:0];
				got.message_bytes = m_axis_tdata[23:8];
				got.byte_valid = m_axis_tuser[0];
				got.message_end = m_axis_tuser[1];
				got.run_last = m_axis_tlast;
				tracker.check_result(got);
			end
			if (s_axis_tvalid && s_axis_tready)
				tracker.take_char(s_axis_tdata, s_axis_tuser, s_axis_tlast);
		end
	end

	// Watchdog: end the run once nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] alpha_char(input logic [5:0] v);
		if (v < 26) return 8'("A" + v);
		if (v < 52) return 8'("a" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		return (v == 62) ? 8'("+") : 8'("/");
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		bit         ok;
		do begin
			c = 8'($urandom_range(255));
			void'(decode_tracker::char_sextet(c, ok));
		end while (ok);
		return c;
	endfunction

	// Offer one item from a falling edge and return at the falling edge after its handshake
	task automatic send_item(input logic [7:0] ch, input logic has, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tuser <= has;
		s_axis_tlast <= eom;
		do begin
			@(posedge clk);
		end while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string txt, input bit close);
		for (int i = 0; i < txt.len(); i++)
			send_item(txt[i], 1'b1, close && (i == txt.len() - 1));
	endtask

	// One random message: mostly well formed, some padded, broken or pure noise
	task automatic send_message();
		int unsigned len;
		int unsigned style;
		int unsigned extra;
		len = $urandom_range(14);
		style = $urandom_range(9);
		if (len == 0 && style < 4) style = 4;
		if (style == 9) begin
			// noise: random bytes with random presence
			extra = $urandom_range(1, 6);
			repeat (extra) send_item(8'($urandom_range(255)), 1'($urandom), 1'b0);
			send_item(8'($urandom_range(255)), 1'($urandom), 1'b1);
			return;
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(alpha_char(6'($urandom_range(63))), 1'b1, (style < 4) && (i == len - 1));
		end
		case (style)
			4, 5: begin
				send_item(8'($urandom_range(255)), 1'b0, 1'b1);
			end
			6, 7: begin
				extra = $urandom_range(1, 2);
				repeat (extra) send_item("=", 1'b1, 1'b0);
				extra = $urandom_range(2);
				repeat (extra) send_item(alpha_char(6'($urandom_range(63))), 1'b1, 1'b0);
				send_item(alpha_char(6'($urandom_range(63))), 1'b1, 1'b1);
			end
			8: begin
				send_item(junk_char(), 1'b1, 1'b0);
				extra = $urandom_range(3);
				repeat (extra) send_item(alpha_char(6'($urandom_range(63))), 1'b1, 1'b0);
				send_item(8'($urandom_range(255)), 1'b0, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic run_phase(input int unsigned idle, input int unsigned stall,
	                         input int unsigned upto);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		while (items_sent < upto) send_message();
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: full group then a bare end marker
		send_text("TWFu", 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// padding stops decoding; the closing pad is ignored
		send_text("QQ==", 1'b1);
		// alphabet extremes, end arriving with the group-completing character
		send_text("+/9z", 1'b1);
		send_text("AZa0", 1'b0);
		// bare end marker closing the group before it, then an item that carries nothing
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'hA5, 1'b0, 1'b0);
		// stray character flushes the partial group; later characters ignored
		send_text("AB", 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_text("D", 1'b1);
		// three-character partial group flushed at the end
		send_text("Zm8", 1'b1);

		run_phase(0, 0, 80);
		run_phase(78, 0, 130);
		run_phase(0, 78, 180);
		run_phase(12, 12, 230);

		// Hold the receiver off while the sender keeps offering items
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		while (items_sent < 250) send_message();

		s_axis_tvalid <= 1'b0;
		recv_stall_pct = 30;
		while (tracker.bytes_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
